/* rtl/bmx_pkg.sv */
// ----------------------------------------------------------------------------
// bmx_pkg
// Shared codes and types for the binary trie maximum-XOR unit.
// ----------------------------------------------------------------------------
package bmx_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

/* rtl/binary_trie_max_xor_unit.sv */
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit
// Accepted transactions walk the trie one level per cycle through the node
// memory read port; an empty query or a rejected insert goes straight to the
// result. One transaction is in flight at a time, and a stalled result holds
// off the next one until the result is taken.
// Reset: trie empty, root links null, free pointer at node 1; no clear pass.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_unit #(
  parameter int VALUE_BITS = 32,
  parameter int NODE_COUNT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] max_xor,
  output logic [1:0]  status
);

  localparam int NW  = $clog2(NODE_COUNT);
  localparam int CW  = NW + 1;
  localparam int LW  = $clog2(VALUE_BITS);
  localparam int LIM = NODE_COUNT - VALUE_BITS;

  bmx_pkg::state_t state;
  logic [LW-1:0]   lvl;
  logic [NW-1:0]   node;
  logic            at_root;
  logic            fresh;
  logic            dead;
  logic            is_query;
  logic [NW-1:0]   root0;
  logic [NW-1:0]   root1;
  logic [CW-1:0]   nf;
  logic            holds;
  logic [1:0]      res_status;

  logic [VALUE_BITS-1:0] cell_v;
  logic [VALUE_BITS-1:0] cell_r;
  logic                  chain_load;
  logic                  chain_shift;
  logic                  r_in;
  logic [31:0]           max_xor_bits;

  logic [2*NW-1:0] mem_q;
  logic [2*NW-1:0] mem_wdata;
  logic            mem_we;
  logic [NW-1:0]   nxt;

  logic            accept;
  logic            cur_bit;
  logic [NW-1:0]   link0;
  logic [NW-1:0]   link1;
  logic [NW-1:0]   want;
  logic [NW-1:0]   opp;
  logic            alloc;
  logic            take;
  logic            full;
  logic            out_free;

  assign in_stall    = (state != bmx_pkg::S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign chain_load  = accept;
  assign chain_shift = (state == bmx_pkg::S_WALK);
  assign cur_bit     = cell_v[VALUE_BITS-1];
  assign full        = (nf > CW'(LIM));
  assign out_free    = !out_valid || !out_stall;

  always_comb begin
    if (at_root) begin
      link0 = root0;
      link1 = root1;
    end else if (fresh) begin
      link0 = '0;
      link1 = '0;
    end else begin
      link0 = mem_q[NW-1:0];
      link1 = mem_q[2*NW-1:NW];
    end
    want  = cur_bit ? link1 : link0;
    opp   = cur_bit ? link0 : link1;
    alloc = !is_query && (want == '0);
    take  = is_query && !dead && (opp != '0);
    if (is_query) begin
      nxt = take ? opp : want;
    end else begin
      nxt = alloc ? nf[NW-1:0] : want;
    end
    r_in      = take;
    mem_we    = chain_shift && alloc && !at_root;
    mem_wdata = cur_bit ? {nf[NW-1:0], link0} : {link1, nf[NW-1:0]};
  end

  genvar gi;
  generate
    for (gi = 0; gi < VALUE_BITS; gi++) begin : g_cell
      logic lb;
      logic vi;
      logic ri;
      if (gi < 32) begin : g_in
        assign lb = value[gi];
      end else begin : g_zero
        assign lb = 1'b0;
      end
      if (gi == 0) begin : g_first
        assign vi = 1'b0;
        assign ri = r_in;
      end else begin : g_next
        assign vi = cell_v[gi-1];
        assign ri = cell_r[gi-1];
      end
      bmx_cell u_cell (
        .clk      (clk),
        .load     (chain_load),
        .shift    (chain_shift),
        .load_bit (lb),
        .v_in     (vi),
        .r_in     (ri),
        .v        (cell_v[gi]),
        .r        (cell_r[gi])
      );
    end
    for (gi = 0; gi < 32; gi++) begin : g_out
      if (gi < VALUE_BITS) begin : g_bit
        assign max_xor_bits[gi] = cell_r[gi];
      end else begin : g_pad
        assign max_xor_bits[gi] = 1'b0;
      end
    end
  endgenerate

  bmx_node_mem #(
    .DEPTH (NODE_COUNT),
    .AW    (NW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (node),
    .wdata (mem_wdata),
    .re    (chain_shift),
    .raddr (nxt),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmx_pkg::S_IDLE;
      root0     <= '0;
      root1     <= '0;
      nf        <= CW'(1);
      holds     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == bmx_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        bmx_pkg::S_IDLE: begin
          if (accept) begin
            is_query <= (operation == bmx_pkg::OP_QUERY);
            lvl      <= LW'(VALUE_BITS - 1);
            node     <= '0;
            at_root  <= 1'b1;
            fresh    <= 1'b0;
            dead     <= 1'b0;
            if (operation == bmx_pkg::OP_QUERY && !holds) begin
              res_status <= bmx_pkg::STATUS_EMPTY;
              state      <= bmx_pkg::S_DONE;
            end else if (operation == bmx_pkg::OP_INSERT && full) begin
              res_status <= bmx_pkg::STATUS_FULL;
              state      <= bmx_pkg::S_DONE;
            end else begin
              res_status <= bmx_pkg::STATUS_OK;
              state      <= bmx_pkg::S_WALK;
            end
          end
        end
        bmx_pkg::S_WALK: begin
          if (alloc) begin
            nf <= nf + CW'(1);
            if (at_root) begin
              if (cur_bit) begin
                root1 <= nf[NW-1:0];
              end else begin
                root0 <= nf[NW-1:0];
              end
            end
          end
          if (is_query && !take && want == '0) begin
            dead <= 1'b1;
          end
          node    <= nxt;
          at_root <= 1'b0;
          fresh   <= alloc;
          lvl     <= lvl - LW'(1);
          if (lvl == '0) begin
            if (!is_query) begin
              holds <= 1'b1;
            end
            state <= bmx_pkg::S_DONE;
          end
        end
        bmx_pkg::S_DONE: begin
          if (out_free) begin
            state <= bmx_pkg::S_IDLE;
          end
        end
        default: state <= bmx_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == bmx_pkg::S_DONE && out_free) begin
      max_xor <= max_xor_bits;
      status  <= res_status;
    end
  end

endmodule

/* rtl/bmx_cell.sv */
// ----------------------------------------------------------------------------
// bmx_cell
// One bit cell of the level chain: holds a value bit and an answer bit and
// hands both to its upper neighbour on every shift.
// ----------------------------------------------------------------------------
module bmx_cell (
  input  logic clk,
  input  logic load,
  input  logic shift,
  input  logic load_bit,
  input  logic v_in,
  input  logic r_in,
  output logic v,
  output logic r
);

  always_ff @(posedge clk) begin
    if (load) begin
      v <= load_bit;
      r <= 1'b0;
    end else if (shift) begin
      v <= v_in;
      r <= r_in;
    end
  end

endmodule

/* rtl/bmx_node_mem.sv */
// ----------------------------------------------------------------------------
// bmx_node_mem
// Node pool: two child links per node, one write and one registered read.
// ----------------------------------------------------------------------------
module bmx_node_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [2*AW-1:0]   wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [2*AW-1:0]   rdata
);

  logic [2*AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
